// ===== hw/rtl/mi4_pkg.sv =====
// Shared types and constants for the 4x4 matrix inverse block.
package mi4_pkg;

  localparam int ELEM_W           = 16;
  localparam int ELEM_FRAC_BITS   = 8;
  localparam int RESULT_FRAC_BITS = 16;
  localparam int OUT_W            = 32;
  localparam int IN_TDATA_W       = 16;
  localparam int OUT_TDATA_W      = 72;

  // cofactor magnitude needs 51 bits plus sign; determinant needs 69 plus sign
  localparam int COF_W  = 52;
  localparam int PROD_W = ELEM_W + COF_W;
  localparam int DET_W  = 70;
  localparam int NUM_W  = COF_W + ELEM_FRAC_BITS + RESULT_FRAC_BITS;
  localparam int REM_W  = DET_W + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int MAT_N   = 16;
  localparam int IDX_W   = $clog2(MAT_N);

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     last;
  } elem_beat_t;

endpackage

// ===== hw/rtl/mi4_front.sv =====
// Input side: counts element beats and tags the last element of each matrix.
module mi4_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mi4_pkg::IN_TDATA_W-1:0]      s_tdata,   // [15:0] elem_value
  output logic                                push_valid,
  input  logic                                push_ready,
  output mi4_pkg::elem_beat_t                 push_data
);

  logic [mi4_pkg::IDX_W-1:0] load_count;

  assign s_tready         = push_ready;
  assign push_valid       = s_tvalid;
  assign push_data.value  = $signed(s_tdata[mi4_pkg::ELEM_W-1:0]);
  assign push_data.last   = (load_count == mi4_pkg::IDX_W'(mi4_pkg::MAT_N - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (s_tvalid && push_ready) begin
      load_count <= load_count + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/mi4_queue.sv =====
// Small FIFO of element beats between the input side and the compute engine.
module mi4_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  mi4_pkg::elem_beat_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mi4_pkg::elem_beat_t pop_data
);

  mi4_pkg::elem_beat_t mem [mi4_pkg::Q_DEPTH];
  logic [mi4_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [mi4_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [mi4_pkg::Q_CNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = (count != mi4_pkg::Q_CNT_W'(mi4_pkg::Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mi4_engine.sv =====
// Compute engine: cofactors and determinant on a shared multiplier, then serial division.
module mi4_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  mi4_pkg::elem_beat_t               pop_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mi4_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast
);

  localparam int EF     = mi4_pkg::ELEM_FRAC_BITS;
  localparam int RF     = mi4_pkg::RESULT_FRAC_BITS;
  localparam int COF_W  = mi4_pkg::COF_W;
  localparam int DET_W  = mi4_pkg::DET_W;
  localparam int NUM_W  = mi4_pkg::NUM_W;
  localparam int REM_W  = mi4_pkg::REM_W;
  localparam int OUT_W  = mi4_pkg::OUT_W;
  localparam int IDX_W  = mi4_pkg::IDX_W;
  localparam int DSHIFT = 4 * EF - RF;
  localparam int DQ_SHR = (DSHIFT > 0) ? DSHIFT : 0;
  localparam int DQ_SHL = (DSHIFT < 0) ? -DSHIFT : 0;
  localparam int DQ_W   = DET_W + DQ_SHL + 1;
  localparam int SAT_W  = (DQ_W > NUM_W + 1) ? DQ_W : NUM_W + 1;
  localparam int BC_W   = $clog2(NUM_W + 1);
  localparam int PAD_W  = mi4_pkg::OUT_TDATA_W - 2 * OUT_W - 2;

  typedef enum logic [2:0] {
    ST_LOAD, ST_COF, ST_DET, ST_FIN, ST_DSTART, ST_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic             clip;
    logic [OUT_W-1:0] value;
  } sat_t;

  function automatic logic [1:0] skip_idx(input logic [1:0] drop, input logic [1:0] n);
    return (n < drop) ? n : n + 2'd1;
  endfunction

  function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
    sat_t res;
    res.clip  = 1'b0;
    res.value = v[OUT_W-1:0];
    if (!((v[SAT_W-1:OUT_W-1] == '0) || (v[SAT_W-1:OUT_W-1] == '1))) begin
      res.clip  = 1'b1;
      res.value = v[SAT_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
    return res;
  endfunction

  state_t state;
  logic signed [mi4_pkg::ELEM_W-1:0] mat [mi4_pkg::MAT_N];
  logic signed [COF_W-1:0]           cof [mi4_pkg::MAT_N];
  logic [IDX_W-1:0]                  ld_idx;
  logic [IDX_W-1:0]                  k;
  logic [1:0]                        t;
  logic [2:0]                        ph;
  logic signed [COF_W-1:0]           opb;
  logic signed [COF_W-1:0]           mn;
  logic signed [COF_W-1:0]           acc;
  logic signed [mi4_pkg::PROD_W-1:0] p;
  logic signed [DET_W-1:0]           det;
  logic [DET_W-1:0]                  dmag;
  logic                              dneg;
  logic                              sing;
  logic [OUT_W-1:0]                  det_out;
  logic [NUM_W-1:0]                  num;
  logic [NUM_W-1:0]                  quo;
  logic [REM_W-1:0]                  rem;
  logic [BC_W-1:0]                   bcnt;
  logic                              aneg;

  logic [1:0]                        row_c;
  logic [1:0]                        col_r;
  logic [1:0]                        ca;
  logic [1:0]                        cb;
  logic [1:0]                        erow;
  logic [1:0]                        ecol;
  logic signed [mi4_pkg::ELEM_W-1:0] e_val;
  logic signed [mi4_pkg::PROD_W-1:0] prod;
  logic [IDX_W-1:0]                  cof_addr;
  logic signed [COF_W-1:0]           cof_val;
  logic signed [COF_W-1:0]           term;
  logic signed [COF_W-1:0]           acc_base;
  logic signed [COF_W-1:0]           acc_next;
  logic signed [DET_W-1:0]           det_next;
  logic signed [DQ_W-1:0]            dq;
  sat_t                              det_sat;
  logic [REM_W-1:0]                  rem_sh;
  logic                              ge;
  logic signed [NUM_W:0]             qx;
  logic signed [NUM_W:0]             qv;
  sat_t                              inv_sat;
  logic                              out_free;

  assign row_c = k[1:0];
  assign col_r = k[3:2];
  assign ca    = (t == 2'd0) ? 2'd1 : 2'd0;
  assign cb    = (t == 2'd2) ? 2'd1 : 2'd2;

  always_comb begin
    erow = skip_idx(row_c, 2'd2);
    ecol = skip_idx(col_r, cb);
    if (state == ST_DET) begin
      erow = 2'd0;
      ecol = k[1:0];
    end else begin
      unique case (ph)
        3'd1: begin
          erow = skip_idx(row_c, 2'd1);
          ecol = skip_idx(col_r, ca);
        end
        3'd2: begin
          erow = skip_idx(row_c, 2'd2);
          ecol = skip_idx(col_r, ca);
        end
        3'd3: begin
          erow = skip_idx(row_c, 2'd1);
          ecol = skip_idx(col_r, cb);
        end
        3'd5: begin
          erow = skip_idx(row_c, 2'd0);
          ecol = skip_idx(col_r, t);
        end
        default: begin
          erow = skip_idx(row_c, 2'd2);
          ecol = skip_idx(col_r, cb);
        end
      endcase
    end
  end

  assign e_val    = mat[{erow, ecol}];
  assign prod     = e_val * opb;
  assign cof_addr = (state == ST_DET) ? {k[1:0], 2'b00} : k;
  assign cof_val  = cof[cof_addr];

  assign term     = $signed(p[COF_W-1:0]);
  assign acc_base = (t == 2'd0) ? '0 : acc;
  assign acc_next = ((t == 2'd1) ^ row_c[0] ^ col_r[0]) ? acc_base - term : acc_base + term;
  assign det_next = det + DET_W'(p);

  assign dq      = (DQ_W'(det) <<< DQ_SHL) >>> DQ_SHR;
  assign det_sat = sat32(SAT_W'(dq));

  assign rem_sh = {rem[REM_W-2:0], num[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dmag});

  assign qx      = $signed({1'b0, quo});
  assign qv      = (aneg ^ dneg) ? -qx : qx;
  assign inv_sat = sat32(SAT_W'(qv));

  assign out_free  = !m_tvalid || m_tready;
  assign pop_ready = (state == ST_LOAD);

  always_ff @(posedge clk) begin
    p <= prod;
    if (pop_valid && pop_ready) begin
      mat[ld_idx] <= pop_data.value;
    end
    if (state == ST_COF && ph == 3'd6 && t == 2'd2) begin
      cof[k] <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      ld_idx   <= '0;
      k        <= '0;
      t        <= '0;
      ph       <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
        m_tlast  <= (k == IDX_W'(mi4_pkg::MAT_N - 1));
        m_tdata  <= {{PAD_W{1'b0}}, !sing && inv_sat.clip, sing,
                     sing ? {OUT_W{1'b0}} : det_out,
                     sing ? {OUT_W{1'b0}} : inv_sat.value};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (pop_valid) begin
            // wraps to zero after the last element
            ld_idx <= ld_idx + 1'b1;
            if (pop_data.last) begin
              state <= ST_COF;
              k     <= '0;
              t     <= '0;
              ph    <= '0;
              det   <= '0;
            end
          end
        end
        ST_COF: begin
          ph <= (ph == 3'd6) ? 3'd0 : ph + 3'd1;
          unique case (ph)
            3'd0: opb <= COF_W'(e_val);
            3'd2: begin
              mn  <= $signed(p[COF_W-1:0]);
              opb <= COF_W'(e_val);
            end
            3'd4: opb <= mn - $signed(p[COF_W-1:0]);
            3'd6: begin
              acc <= acc_next;
              if (t == 2'd2) begin
                t <= '0;
                k <= k + 1'b1;
                if (k == IDX_W'(mi4_pkg::MAT_N - 1)) begin
                  state <= ST_DET;
                end
              end else begin
                t <= t + 2'd1;
              end
            end
            default: ;
          endcase
        end
        ST_DET: begin
          ph <= (ph == 3'd2) ? 3'd0 : ph + 3'd1;
          if (ph == 3'd0) begin
            opb <= cof_val;
          end else if (ph == 3'd2) begin
            det <= det_next;
            k   <= (k == IDX_W'(3)) ? '0 : k + 1'b1;
            if (k == IDX_W'(3)) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          sing    <= (det == '0);
          dneg    <= det[DET_W-1];
          dmag    <= det[DET_W-1] ? -det : det;
          det_out <= det_sat.value;
          state   <= ST_DSTART;
        end
        ST_DSTART: begin
          aneg  <= cof_val[COF_W-1];
          num   <= {(cof_val[COF_W-1] ? -cof_val : cof_val), {(EF + RF){1'b0}}};
          rem   <= '0;
          quo   <= '0;
          bcnt  <= '0;
          state <= sing ? ST_EMIT : ST_DIV;
        end
        ST_DIV: begin
          rem  <= ge ? rem_sh - {1'b0, dmag} : rem_sh;
          num  <= {num[NUM_W-2:0], 1'b0};
          quo  <= {quo[NUM_W-2:0], ge};
          bcnt <= bcnt + 1'b1;
          if (bcnt == BC_W'(NUM_W - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            k     <= k + 1'b1;
            state <= (k == IDX_W'(mi4_pkg::MAT_N - 1)) ? ST_LOAD : ST_DSTART;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

// ===== hw/rtl/matrix4_inverse.sv =====
// 4x4 matrix inverse by adjugate and determinant: 16 elements in, 16 inverse elements out.
// After the 16th element: the cofactors, then the determinant, then a setup step, then per result
// a restoring division of NUM_W quotient bits.
// One matrix is computed at a time, on the single multiplier and the bit-serial divider.
// The input queue takes up to 4 beats of the next matrix while one is being computed.
// Synchronous reset empties the queue, clears the element count and drops the output beat.
module matrix4_inverse (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mi4_pkg::IN_TDATA_W-1:0]  s_tdata,   // [15:0] elem_value
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mi4_pkg::OUT_TDATA_W-1:0] m_tdata,   // [31:0] inv_value, [63:32] det_value,
                                                     // [64] singular, [65] saturated
  output logic                            m_tlast    // last_result
);

  logic                push_valid;
  logic                push_ready;
  mi4_pkg::elem_beat_t push_data;
  logic                pop_valid;
  logic                pop_ready;
  mi4_pkg::elem_beat_t pop_data;

  mi4_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mi4_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mi4_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== dv/matrix4_inverse_tb.sv =====
// Self-checking testbench for matrix4_inverse: directed and random matrices vs a predictor or known answers.
module matrix4_inverse_tb;

  typedef struct {
    logic [31:0] inv;
    logic [31:0] det;
    logic        sing;
    logic        sat;
    logic        last;
  } inv_result_t;

  typedef enum {CHK_PREDICT, CHK_IDENTITY, CHK_SINGULAR} chk_kind_t;

  typedef struct {
    logic signed [15:0] elem [16];
    chk_kind_t          kind;
  } mat_row_t;

  logic                            clk = 0;
  logic                            rst = 1;
  logic                            s_tvalid = 0;
  logic                            s_tready;
  logic [mi4_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 0;
  logic [mi4_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tlast;

  inv_result_t        inv_expected[$];
  logic signed [15:0] loaded [16];
  int                 load_idx = 0;
  int                 errors = 0;
  int                 results_seen = 0;
  bit                 feed_done = 0;

  matrix4_inverse DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [31:0] clip32(input logic signed [127:0] v, output logic hit);
    hit = 1'b0;
    if (v > 128'sh7FFFFFFF) begin
      hit = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sh80000000) begin
      hit = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint minor_det(input int r, input int c);
    longint m [3][3];
    int     a, b;
    a = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == r) continue;
      b = 0;
      for (int j = 0; j < 4; j++) begin
        if (j == c) continue;
        m[a][b] = longint'(loaded[i*4+j]);
        b++;
      end
      a++;
    end
    return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
         - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
         + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
  endfunction

  // adjugate / determinant of the loaded matrix, queued as 16 expected beats
  function automatic void predict_inverse();
    longint             adj [16];
    logic signed [127:0] det, dq, q, a128, b128;
    logic        [127:0] dmag, num, uq;
    logic [31:0]         det_out;
    logic                clipd, dneg, aneg;
    inv_result_t         res;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        adj[r*4+c] = ((r + c) & 1) ? -minor_det(c, r) : minor_det(c, r);
    det = '0;
    for (int c = 0; c < 4; c++) begin
      a128 = loaded[c];
      b128 = adj[c*4];
      det += a128 * b128;
    end
    dq = det >>> (4 * mi4_pkg::ELEM_FRAC_BITS - mi4_pkg::RESULT_FRAC_BITS);
    det_out = clip32(dq, clipd);
    dneg = det < 0;
    dmag = dneg ? -det : det;
    for (int k = 0; k < 16; k++) begin
      res.sing = (det == 0);
      res.inv  = '0;
      res.sat  = 1'b0;
      if (!res.sing) begin
        aneg = adj[k] < 0;
        a128 = adj[k];
        num  = (aneg ? -a128 : a128)
               << (mi4_pkg::ELEM_FRAC_BITS + mi4_pkg::RESULT_FRAC_BITS);
        uq   = num / dmag;
        q    = (aneg != dneg) ? -$signed(uq) : $signed(uq);
        res.inv = clip32(q, res.sat);
      end
      res.det  = res.sing ? 32'h0 : det_out;
      res.last = (k == 15);
      inv_expected.push_back(res);
    end
  endfunction

  task automatic send_beat(input logic signed [15:0] v, input bit quick);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    loaded[load_idx] = v;
    load_idx++;
    if (load_idx == 16) begin
      load_idx = 0;
      predict_inverse();
    end
    if (!quick) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_matrix(input mat_row_t m, input bit quick);
    inv_result_t res;
    if (m.kind != CHK_PREDICT) begin
      for (int k = 0; k < 16; k++) loaded[k] = m.elem[k];
      for (int k = 0; k < 15; k++) send_beat(m.elem[k], quick);
      // last element: drop the predicted beats and type in the known answer
      send_beat(m.elem[15], quick);
      repeat (16) void'(inv_expected.pop_back());
      for (int k = 0; k < 16; k++) begin
        res.sing = (m.kind == CHK_SINGULAR);
        res.sat  = 1'b0;
        res.last = (k == 15);
        res.det  = res.sing ? 32'h0 : 32'h00010000;
        res.inv  = (!res.sing && (k % 5 == 0)) ? 32'h00010000 : 32'h0;
        inv_expected.push_back(res);
      end
    end else begin
      for (int k = 0; k < 16; k++) send_beat(m.elem[k], quick);
    end
  endtask

  function automatic logic signed [15:0] rand_elem(input int style);
    case (style)
      0: return 16'($urandom());
      1: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      2: return ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
      default: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
    endcase
  endfunction

  initial begin
    mat_row_t directed [3];
    mat_row_t m;
    int       style;
    for (int k = 0; k < 16; k++) begin
      directed[0].elem[k] = (k % 5 == 0) ? 16'sh0100 : 16'sh0;
      directed[1].elem[k] = 16'sh0;
      directed[2].elem[k] = (k % 5 == 0) ? 16'sh8000 : 16'sh0;
    end
    directed[0].kind = CHK_IDENTITY;
    directed[1].kind = CHK_SINGULAR;
    directed[2].kind = CHK_PREDICT;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_matrix(directed[i], 1'b0);

    for (int n = 0; n < 16; n++) begin
      style = $urandom_range(0, 4);
      m.kind = CHK_PREDICT;
      for (int k = 0; k < 16; k++) m.elem[k] = rand_elem(style == 4 ? 1 : style);
      if (style == 4) begin
        // diagonally dominant, usually well-conditioned
        for (int k = 0; k < 4; k++) m.elem[k*5] = $signed(16'($urandom_range(2048, 8191)));
      end else if (style == 3) begin
        // repeated row: exact zero determinant
        for (int c = 0; c < 4; c++) m.elem[12+c] = m.elem[4+c];
      end
      send_matrix(m, n == 5);
    end
    s_tvalid <= 1'b0;
    feed_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off while the sender keeps pushing
  initial begin
    int stall;
    bit held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 20) begin
        held = 1;
        m_tready <= 1'b0;
        repeat (4000) @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    inv_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (inv_expected.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, m_tdata);
        errors++;
      end else begin
        e = inv_expected.pop_front();
        if (m_tdata[31:0] !== e.inv) begin
          $display("%0t: inv_value exp %h got %h", $time, e.inv, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] !== e.det) begin
          $display("%0t: det_value exp %h got %h", $time, e.det, m_tdata[63:32]);
          errors++;
        end
        if (m_tdata[64] !== e.sing) begin
          $display("%0t: singular exp %b got %b", $time, e.sing, m_tdata[64]);
          errors++;
        end
        if (m_tdata[65] !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, m_tdata[65]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t: last exp %b got %b", $time, e.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (feed_done);
    while (inv_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("matrix4_inverse regression: pass");
    else
      $display("matrix4_inverse regression: fail");
    $finish;
  end

  initial begin
    #5000000;
    $display("matrix4_inverse regression: fail");
    $finish;
  end

endmodule

// ===== matrix4_inverse.f =====
hw/rtl/mi4_pkg.sv
hw/rtl/mi4_front.sv
hw/rtl/mi4_queue.sv
hw/rtl/mi4_engine.sv
hw/rtl/matrix4_inverse.sv
dv/matrix4_inverse_tb.sv
